/* rtl/core/ucd_pkg.sv */
// Shared types and constants for the UTF-8 character diff unit.
// No dependencies.
package ucd_pkg;

   // request operation codes
   localparam logic [1:0] OPER_APPEND_OLD = 2'd0;
   localparam logic [1:0] OPER_APPEND_NEW = 2'd1;
   localparam logic [1:0] OPER_COMPUTE    = 2'd2;
   localparam logic [1:0] OPER_READ       = 2'd3;

   // edit op kinds
   localparam logic [1:0] KIND_KEEP   = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_INSERT = 2'd2;

   // UTF-8 lead byte classes
   localparam logic [7:0] UTF_ASCII_LIM = 8'h80;
   localparam logic [7:0] UTF_M2        = 8'hE0;
   localparam logic [7:0] UTF_L2        = 8'hC0;
   localparam logic [7:0] UTF_M3        = 8'hF0;
   localparam logic [7:0] UTF_L3        = 8'hE0;
   localparam logic [7:0] UTF_M4        = 8'hF8;
   localparam logic [7:0] UTF_L4        = 8'hF0;

   localparam int CP_W = 21;

   typedef struct packed {
      logic [1:0]      kind;
      logic [CP_W-1:0] cp;
   } op_type;

endpackage

/* rtl/core/utf8_lcs_char_diff_unit.sv */
// UTF-8 character diff unit: byte stores, decoder, LCS table fill, backtrack,
// cleanup pass and op readout, all built around on-chip memories.
// Depends on ucd_pkg.
//
// Usage:
//   req channel: tuser[1:0] = operation, tdata[7:0] = data byte.
//   Append transactions (old/new byte) give no response.
//   A compute transaction decodes both strings, fills the LCS length table,
//   backtracks and runs the optional cleanup pass, then returns one response
//   with op_count and overflow.
//   Each byte, table cell, backtrack step and reverse step first addresses a
//   memory, then uses its registered read data.
//   A read transaction returns the next op through the op store read port,
//   or a response with none_left set when no op is left.
//   csr channel: one write data bit, cleanup_enable; always ready.
//   Reset (synchronous, active high) empties both stores, clears the op
//   count, read pointer and overflow flag. Memory contents are not cleared.
//   A response stays in the output register until rsp_tready; while it waits
//   no new request is taken.
module utf8_lcs_char_diff_unit
   import ucd_pkg::*;
#(
   parameter int MAX_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [20:0] code_point, [29:21] op_count, zero fill
   output logic [3:0]  rsp_tuser,   // [1:0] op_kind, [2] none_left, [3] overflow
   output logic        rsp_tlast,   // last_op
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_data     // cleanup_enable
);

   localparam int N    = MAX_BYTES;
   localparam int CW   = $clog2(N + 1);        // counts 0..N
   localparam int AW   = $clog2(N);            // store index
   localparam int NOPS = 2 * N;
   localparam int OCW  = $clog2(NOPS + 1);     // op counts
   localparam int OAW  = $clog2(NOPS);         // op index
   localparam int LW   = $clog2(N + 1);        // LCS length
   localparam int TD   = (N + 1) * (N + 1);
   localparam int TW   = $clog2(TD);
   localparam logic [TW-1:0] TSTEP = TW'(N + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDOP   = 4'd1;
   localparam logic [3:0] S_DEC_RD = 4'd2;
   localparam logic [3:0] S_DEC_EX = 4'd3;
   localparam logic [3:0] S_ROW_RD = 4'd4;
   localparam logic [3:0] S_ROW_CP = 4'd5;
   localparam logic [3:0] S_FIL_RD = 4'd6;
   localparam logic [3:0] S_FIL_EX = 4'd7;
   localparam logic [3:0] S_BT_RD  = 4'd8;
   localparam logic [3:0] S_BT_EX  = 4'd9;
   localparam logic [3:0] S_REV_RD = 4'd10;
   localparam logic [3:0] S_REV_EX = 4'd11;
   localparam logic [3:0] S_DONE   = 4'd12;

   // memories
   logic [7:0]    mem_old_byte [N];
   logic [7:0]    mem_new_byte [N];
   logic [CP_W-1:0] mem_old_pt [N];
   logic [CP_W-1:0] mem_new_pt [N];
   logic [LW-1:0] mem_len [TD];
   op_type        mem_rev [NOPS];
   op_type        mem_ops [NOPS];

   // memory read data registers
   logic [7:0]      old_byte_rd_ff, new_byte_rd_ff;
   logic [CP_W-1:0] old_pt_rd_ff, new_pt_rd_ff;
   logic [LW-1:0]   len_a_rd_ff, len_b_rd_ff;
   op_type          rev_rd_ff, ops_rd_ff;

   // memory controls
   logic            ob_we, nb_we;
   logic [AW-1:0]   ob_wa, nb_wa, ob_ra, nb_ra;
   logic            op_we, np_we;
   logic [AW-1:0]   pt_wa, op_ra, np_ra;
   logic [CP_W-1:0] pt_wd;
   logic            len_we;
   logic [TW-1:0]   len_wa, len_raa, len_rab;
   logic [LW-1:0]   len_wd;
   logic            rev_we, ops_we;
   logic [OAW-1:0]  rev_wa, rev_ra, ops_wa, ops_ra;
   op_type          rev_wd, ops_wd;

   // control state
   logic [3:0]      state_ff, state_in;
   logic            clean_ff, clean_in;
   logic [CW-1:0]   old_fill_ff, old_fill_in, new_fill_ff, new_fill_in;
   logic            drop_ff, drop_in;
   logic [OCW-1:0]  total_ff, total_in, rp_ff, rp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_kind_ff, rsp_kind_in;
   logic [CP_W-1:0] rsp_cp_ff, rsp_cp_in;
   logic [8:0]      rsp_count_ff, rsp_count_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_none_ff, rsp_none_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   // working registers
   logic            dsel_ff, dsel_in;          // 0 old string, 1 new string
   logic [CW-1:0]   didx_ff, didx_in;
   logic [1:0]      drem_ff, drem_in;
   logic [CP_W-1:0] dacc_ff, dacc_in;
   logic [CW-1:0]   dk_ff, dk_in;
   logic [CW-1:0]   na_ff, na_in, nb_ff, nb_in;
   logic [CW-1:0]   fi_ff, fi_in, fj_ff, fj_in;
   logic [TW-1:0]   rbase_ff, rbase_in, ubase_ff, ubase_in;
   logic [CP_W-1:0] apt_ff, apt_in;
   logic [LW-1:0]   left_ff, left_in, diag_ff, diag_in;
   logic [OCW-1:0]  nops_ff, nops_in, rr_ff, rr_in, ww_ff, ww_in;
   logic            pend_v_ff, pend_v_in;
   op_type          pend_ff, pend_in;

   // decode / cell helpers
   logic [7:0]      dbyte;
   logic [CW-1:0]   dfill;
   logic [CW:0]     dpos;
   logic [LW-1:0]   up_v, lf_v, cell_v;
   logic            pt_eq;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_cp_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_none_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      clean_in     = clean_ff;
      old_fill_in  = old_fill_ff;
      new_fill_in  = new_fill_ff;
      drop_in      = drop_ff;
      total_in     = total_ff;
      rp_in        = rp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cp_in    = rsp_cp_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      dsel_in = dsel_ff; didx_in = didx_ff; drem_in = drem_ff; dacc_in = dacc_ff;
      dk_in = dk_ff; na_in = na_ff; nb_in = nb_ff;
      fi_in = fi_ff; fj_in = fj_ff; rbase_in = rbase_ff; ubase_in = ubase_ff;
      apt_in = apt_ff; left_in = left_ff; diag_in = diag_ff;
      nops_in = nops_ff; rr_in = rr_ff; ww_in = ww_ff;
      pend_v_in = pend_v_ff; pend_in = pend_ff;

      ob_we = 1'b0; nb_we = 1'b0;
      ob_wa = old_fill_ff[AW-1:0]; nb_wa = new_fill_ff[AW-1:0];
      ob_ra = didx_ff[AW-1:0];     nb_ra = didx_ff[AW-1:0];
      op_we = 1'b0; np_we = 1'b0;
      pt_wa = dk_ff[AW-1:0];
      pt_wd = '0;
      op_ra = AW'(fi_ff - CW'(1));
      np_ra = AW'(fj_ff - CW'(1));
      len_we  = 1'b0;
      len_wa  = TW'(rbase_ff + TW'(fj_ff));
      len_raa = TW'(ubase_ff + TW'(fj_ff));
      len_rab = TW'(ubase_ff + TW'(fj_ff));
      len_wd  = '0;
      rev_we = 1'b0; rev_wa = nops_ff[OAW-1:0]; rev_wd = '0;
      rev_ra = OAW'(rr_ff - OCW'(1));
      ops_we = 1'b0; ops_wa = ww_ff[OAW-1:0]; ops_wd = pend_ff;
      ops_ra = rp_ff[OAW-1:0];

      dbyte  = dsel_ff ? new_byte_rd_ff : old_byte_rd_ff;
      dfill  = dsel_ff ? new_fill_ff : old_fill_ff;
      dpos   = {1'b0, didx_ff};
      up_v   = (fi_ff <= CW'(1)) ? '0 : len_b_rd_ff;
      lf_v   = (fj_ff <= CW'(1)) ? '0 : len_a_rd_ff;
      pt_eq  = (old_pt_rd_ff == new_pt_rd_ff);
      cell_v = '0;

      if (csr_valid) clean_in = csr_data[0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               unique case (req_tuser)
                  OPER_APPEND_OLD: begin
                     if (old_fill_ff < CW'(N)) begin
                        ob_we = 1'b1;
                        old_fill_in = CW'(old_fill_ff + CW'(1));
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OPER_APPEND_NEW: begin
                     if (new_fill_ff < CW'(N)) begin
                        nb_we = 1'b1;
                        new_fill_in = CW'(new_fill_ff + CW'(1));
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  OPER_COMPUTE: begin
                     dsel_in = 1'b0; didx_in = '0; drem_in = '0; dk_in = '0;
                     state_in = S_DEC_RD;
                  end
                  OPER_READ: begin
                     if (rp_ff < total_ff) begin
                        state_in = S_RDOP;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in = KIND_KEEP; rsp_cp_in = '0; rsp_count_in = '0;
                        rsp_last_in = 1'b0; rsp_none_in = 1'b1; rsp_ovf_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RDOP: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = ops_rd_ff.kind;
            rsp_cp_in    = ops_rd_ff.cp;
            rsp_count_in = '0;
            rsp_none_in  = 1'b0;
            rsp_ovf_in   = 1'b0;
            rsp_last_in  = (OCW'(rp_ff + OCW'(1)) == total_ff);
            rp_in        = OCW'(rp_ff + OCW'(1));
            state_in     = S_IDLE;
         end
         S_DEC_RD: begin
            if (didx_ff == dfill) begin
               if (!dsel_ff) begin
                  na_in = dk_ff;
                  dsel_in = 1'b1; didx_in = '0; drem_in = '0; dk_in = '0;
               end else begin
                  nb_in = dk_ff;
                  if ((na_ff == '0) || (dk_ff == '0)) begin
                     fi_in = na_ff; fj_in = dk_ff;
                     nops_in = '0;
                     state_in = S_BT_RD;
                  end else begin
                     fi_in = CW'(1);
                     rbase_in = TSTEP;
                     ubase_in = '0;
                     state_in = S_ROW_RD;
                  end
               end
            end else begin
               state_in = S_DEC_EX;
            end
         end
         S_DEC_EX: begin
            didx_in  = CW'(didx_ff + CW'(1));
            state_in = S_DEC_RD;
            if (drem_ff != 2'd0) begin
               dacc_in = {dacc_ff[CP_W-7:0], dbyte[5:0]};
               drem_in = drem_ff - 2'd1;
               if (drem_ff == 2'd1) begin
                  op_we = !dsel_ff; np_we = dsel_ff;
                  pt_wd = {dacc_ff[CP_W-7:0], dbyte[5:0]};
                  dk_in = CW'(dk_ff + CW'(1));
               end
            end else begin
               priority if (dbyte < UTF_ASCII_LIM) begin
                  op_we = !dsel_ff; np_we = dsel_ff;
                  pt_wd = CP_W'(dbyte);
                  dk_in = CW'(dk_ff + CW'(1));
               end else if (((dbyte & UTF_M2) == UTF_L2) &&
                            ((dpos + (CW+1)'(1)) < {1'b0, dfill})) begin
                  dacc_in = CP_W'(dbyte[4:0]); drem_in = 2'd1;
               end else if (((dbyte & UTF_M3) == UTF_L3) &&
                            ((dpos + (CW+1)'(2)) < {1'b0, dfill})) begin
                  dacc_in = CP_W'(dbyte[3:0]); drem_in = 2'd2;
               end else if (((dbyte & UTF_M4) == UTF_L4) &&
                            ((dpos + (CW+1)'(3)) < {1'b0, dfill})) begin
                  dacc_in = CP_W'(dbyte[2:0]); drem_in = 2'd3;
               end else begin
                  // stray continuation, invalid or truncated lead: raw byte
                  op_we = !dsel_ff; np_we = dsel_ff;
                  pt_wd = CP_W'(dbyte);
                  dk_in = CW'(dk_ff + CW'(1));
               end
            end
         end
         S_ROW_RD: state_in = S_ROW_CP;
         S_ROW_CP: begin
            apt_in = old_pt_rd_ff;
            fj_in = CW'(1); left_in = '0; diag_in = '0;
            state_in = S_FIL_RD;
         end
         S_FIL_RD: state_in = S_FIL_EX;
         S_FIL_EX: begin
            if (apt_ff == new_pt_rd_ff) cell_v = LW'(diag_ff + LW'(1));
            else cell_v = (up_v > left_ff) ? up_v : left_ff;
            len_we = 1'b1; len_wd = cell_v;
            left_in = cell_v; diag_in = up_v;
            if (fj_ff == nb_ff) begin
               if (fi_ff == na_ff) begin
                  fj_in = nb_ff; nops_in = '0;
                  state_in = S_BT_RD;
               end else begin
                  fi_in = CW'(fi_ff + CW'(1));
                  rbase_in = TW'(rbase_ff + TSTEP);
                  ubase_in = TW'(ubase_ff + TSTEP);
                  state_in = S_ROW_RD;
               end
            end else begin
               fj_in = CW'(fj_ff + CW'(1));
               state_in = S_FIL_RD;
            end
         end
         S_BT_RD: begin
            len_raa = TW'(rbase_ff + TW'(fj_ff) - TW'(1));
            len_rab = TW'(ubase_ff + TW'(fj_ff));
            if ((fi_ff == '0) && (fj_ff == '0)) begin
               rr_in = nops_ff; ww_in = '0; pend_v_in = 1'b0;
               state_in = S_REV_RD;
            end else begin
               state_in = S_BT_EX;
            end
         end
         S_BT_EX: begin
            rev_we = 1'b1;
            nops_in = OCW'(nops_ff + OCW'(1));
            state_in = S_BT_RD;
            priority if ((fi_ff != '0) && (fj_ff != '0) && pt_eq) begin
               rev_wd = '{kind: KIND_KEEP, cp: old_pt_rd_ff};
               fi_in = CW'(fi_ff - CW'(1)); fj_in = CW'(fj_ff - CW'(1));
               rbase_in = TW'(rbase_ff - TSTEP); ubase_in = TW'(ubase_ff - TSTEP);
            end else if ((fj_ff != '0) && ((fi_ff == '0) || (lf_v >= up_v))) begin
               rev_wd = '{kind: KIND_INSERT, cp: new_pt_rd_ff};
               fj_in = CW'(fj_ff - CW'(1));
            end else begin
               rev_wd = '{kind: KIND_DELETE, cp: old_pt_rd_ff};
               fi_in = CW'(fi_ff - CW'(1));
               rbase_in = TW'(rbase_ff - TSTEP); ubase_in = TW'(ubase_ff - TSTEP);
            end
         end
         S_REV_RD: begin
            if (rr_ff == '0) begin
               if (pend_v_ff) begin
                  ops_we = 1'b1;
                  ww_in = OCW'(ww_ff + OCW'(1));
               end
               pend_v_in = 1'b0;
               state_in = S_DONE;
            end else begin
               rr_in = OCW'(rr_ff - OCW'(1));
               state_in = S_REV_EX;
            end
         end
         S_REV_EX: begin
            state_in = S_REV_RD;
            if (pend_v_ff && clean_ff && (pend_ff.cp == rev_rd_ff.cp) &&
                (((pend_ff.kind == KIND_DELETE) && (rev_rd_ff.kind == KIND_INSERT)) ||
                 ((pend_ff.kind == KIND_INSERT) && (rev_rd_ff.kind == KIND_DELETE)))) begin
               ops_we = 1'b1;
               ops_wd = '{kind: KIND_KEEP, cp: pend_ff.cp};
               ww_in = OCW'(ww_ff + OCW'(1));
               pend_v_in = 1'b0;
            end else begin
               if (pend_v_ff) begin
                  ops_we = 1'b1;
                  ww_in = OCW'(ww_ff + OCW'(1));
               end
               pend_in = rev_rd_ff;
               pend_v_in = 1'b1;
            end
         end
         S_DONE: begin
            total_in = ww_ff;
            rp_in = '0;
            rsp_valid_in = 1'b1;
            rsp_kind_in = KIND_KEEP; rsp_cp_in = '0;
            rsp_count_in = 9'(ww_ff);
            rsp_last_in = 1'b0; rsp_none_in = 1'b0; rsp_ovf_in = drop_ff;
            drop_in = 1'b0;
            old_fill_in = '0; new_fill_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clean_ff     <= 1'b0;
         old_fill_ff  <= '0;
         new_fill_ff  <= '0;
         drop_ff      <= 1'b0;
         total_ff     <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clean_ff     <= clean_in;
         old_fill_ff  <= old_fill_in;
         new_fill_ff  <= new_fill_in;
         drop_ff      <= drop_in;
         total_ff     <= total_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in; rsp_cp_ff <= rsp_cp_in; rsp_count_ff <= rsp_count_in;
      rsp_last_ff <= rsp_last_in; rsp_none_ff <= rsp_none_in; rsp_ovf_ff <= rsp_ovf_in;
      dsel_ff <= dsel_in; didx_ff <= didx_in; drem_ff <= drem_in; dacc_ff <= dacc_in;
      dk_ff <= dk_in; na_ff <= na_in; nb_ff <= nb_in;
      fi_ff <= fi_in; fj_ff <= fj_in; rbase_ff <= rbase_in; ubase_ff <= ubase_in;
      apt_ff <= apt_in; left_ff <= left_in; diag_ff <= diag_in;
      nops_ff <= nops_in; rr_ff <= rr_in; ww_ff <= ww_in; pend_ff <= pend_in;
   end

   // byte stores
   always_ff @(posedge clock) begin
      if (ob_we) mem_old_byte[ob_wa] <= req_tdata;
      old_byte_rd_ff <= mem_old_byte[ob_ra];
   end
   always_ff @(posedge clock) begin
      if (nb_we) mem_new_byte[nb_wa] <= req_tdata;
      new_byte_rd_ff <= mem_new_byte[nb_ra];
   end

   // code point stores
   always_ff @(posedge clock) begin
      if (op_we) mem_old_pt[pt_wa] <= pt_wd;
      old_pt_rd_ff <= mem_old_pt[op_ra];
   end
   always_ff @(posedge clock) begin
      if (np_we) mem_new_pt[pt_wa] <= pt_wd;
      new_pt_rd_ff <= mem_new_pt[np_ra];
   end

   // LCS length table: one write, two reads
   always_ff @(posedge clock) begin
      if (len_we) mem_len[len_wa] <= len_wd;
      len_a_rd_ff <= mem_len[len_raa];
      len_b_rd_ff <= mem_len[len_rab];
   end

   // reversed backtrack ops and final op store
   always_ff @(posedge clock) begin
      if (rev_we) mem_rev[rev_wa] <= rev_wd;
      rev_rd_ff <= mem_rev[rev_ra];
   end
   always_ff @(posedge clock) begin
      if (ops_we) mem_ops[ops_wa] <= ops_wd;
      ops_rd_ff <= mem_ops[ops_ra];
   end

endmodule

/* bench/utf8_lcs_char_diff_unit_tb.sv */
// Self-checking bench for the UTF-8 LCS character diff unit: byte appends,
// compute and op readout are predicted in-bench and compared per response.
// Depends on ucd_pkg and utf8_lcs_char_diff_unit.
module utf8_lcs_char_diff_unit_tb;
   import ucd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 128;
   localparam int OPS_DEPTH   = 2 * STORE_DEPTH;
   localparam int IDLE_LIMIT  = 200000;

   // one request transaction
   typedef struct packed {
      logic [1:0] oper;
      logic [7:0] data;
   } req_item_t;

   // one expected response transaction
   typedef struct packed {
      logic [1:0]      kind;
      logic [CP_W-1:0] cp;
      logic [8:0]      count;
      logic            last;
      logic            empty;
      logic            ovf;
   } rsp_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_data = '0;

   utf8_lcs_char_diff_unit #(.MAX_BYTES(STORE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: mirrors the unit's byte stores, op list and flags.
   // ---------------------------------------------------------------------
   logic [7:0]      old_store [STORE_DEPTH];
   logic [7:0]      new_store [STORE_DEPTH];
   int              old_len, new_len;
   op_type          edit_script [OPS_DEPTH];
   int              script_len, script_ptr;
   logic            bytes_lost;
   logic            merge_en;

   req_item_t pending_reqs[$];
   rsp_item_t expected_rsps[$];
   int        mismatches = 0;
   int        accepted_reqs = 0;
   int        idle_cycles = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        hold_off_cycles = 0;
   bit        timed_out = 0;
   bit        req_accepted = 0;

   // UTF-8 decode, no continuation checks; truncated/invalid leads pass through
   function automatic int decode_points(input logic [7:0] src [STORE_DEPTH], input int n,
                                        output logic [CP_W-1:0] dst [STORE_DEPTH]);
      int i, k;
      logic [7:0] c;
      i = 0;
      k = 0;
      while (i < n) begin
         c = src[i];
         if (c < 8'h80) begin
            dst[k] = CP_W'(c);
            i += 1;
         end else if ((c & 8'hE0) == 8'hC0 && i + 1 < n) begin
            dst[k] = {10'd0, c[4:0], src[i+1][5:0]};
            i += 2;
         end else if ((c & 8'hF0) == 8'hE0 && i + 2 < n) begin
            dst[k] = {5'd0, c[3:0], src[i+1][5:0], src[i+2][5:0]};
            i += 3;
         end else if ((c & 8'hF8) == 8'hF0 && i + 3 < n) begin
            dst[k] = {c[2:0], src[i+1][5:0], src[i+2][5:0], src[i+3][5:0]};
            i += 4;
         end else begin
            dst[k] = CP_W'(c);
            i += 1;
         end
         k++;
      end
      return k;
   endfunction

   // LCS fill, backtrack (insert wins ties), optional delete/insert merge
   task automatic build_edit_script();
      logic [CP_W-1:0] pa [STORE_DEPTH];
      logic [CP_W-1:0] pb [STORE_DEPTH];
      int     lcs [STORE_DEPTH+1][STORE_DEPTH+1];
      op_type rev [OPS_DEPTH];
      op_type a, b;
      int     na, nb, i, j, n, r, w;
      na = decode_points(old_store, old_len, pa);
      nb = decode_points(new_store, new_len, pb);
      for (j = 0; j <= nb; j++) lcs[0][j] = 0;
      for (i = 1; i <= na; i++) begin
         lcs[i][0] = 0;
         for (j = 1; j <= nb; j++) begin
            if (pa[i-1] == pb[j-1]) lcs[i][j] = lcs[i-1][j-1] + 1;
            else lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ? lcs[i-1][j] : lcs[i][j-1];
         end
      end
      i = na;
      j = nb;
      n = 0;
      while ((i > 0 || j > 0) && n < OPS_DEPTH) begin
         if (i > 0 && j > 0 && pa[i-1] == pb[j-1]) begin
            rev[n++] = '{KIND_KEEP, pa[i-1]};
            i--;
            j--;
         end else if (j > 0 && (i == 0 || lcs[i][j-1] >= lcs[i-1][j])) begin
            rev[n++] = '{KIND_INSERT, pb[j-1]};
            j--;
         end else begin
            rev[n++] = '{KIND_DELETE, pa[i-1]};
            i--;
         end
      end
      for (i = 0; i < n; i++) edit_script[i] = rev[n-1-i];
      if (merge_en && n >= 2) begin
         r = 0;
         w = 0;
         while (r < n) begin
            if (r + 1 < n) begin
               a = edit_script[r];
               b = edit_script[r+1];
               if (a.cp == b.cp &&
                   ((a.kind == KIND_DELETE && b.kind == KIND_INSERT) ||
                    (a.kind == KIND_INSERT && b.kind == KIND_DELETE))) begin
                  edit_script[w++] = '{KIND_KEEP, a.cp};
                  r += 2;
                  continue;
               end
            end
            edit_script[w++] = edit_script[r++];
         end
         n = w;
      end
      script_len = n;
      script_ptr = 0;
   endtask

   // advance the predictor by one accepted request
   task automatic predict_request(input req_item_t it);
      rsp_item_t e;
      e = '0;
      case (it.oper)
         OPER_APPEND_OLD: begin
            if (old_len < STORE_DEPTH) old_store[old_len++] = it.data;
            else bytes_lost = 1'b1;
         end
         OPER_APPEND_NEW: begin
            if (new_len < STORE_DEPTH) new_store[new_len++] = it.data;
            else bytes_lost = 1'b1;
         end
         OPER_COMPUTE: begin
            build_edit_script();
            e.count = 9'(script_len);
            e.ovf = bytes_lost;
            bytes_lost = 1'b0;
            old_len = 0;
            new_len = 0;
            expected_rsps.insert(expected_rsps.size(), e);
         end
         default: begin
            if (script_ptr < script_len) begin
               e.kind = edit_script[script_ptr].kind;
               e.cp = edit_script[script_ptr].cp;
               script_ptr++;
               e.last = (script_ptr == script_len);
            end else begin
               e.empty = 1'b1;
            end
            expected_rsps.insert(expected_rsps.size(), e);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents queued requests at the falling edge, random gaps.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_accepted) begin
            // hold the current transaction
         end else if (pending_reqs.size() > 0 &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].oper;
            req_tdata  <= pending_reqs[0].data;
            void'(pending_reqs.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
         req_accepted = 1'b0;
         if (hold_off_cycles > 0) rsp_tready <= 1'b0;
         else rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted down in cycles
   always @(negedge clock) begin
      if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on accepted requests, checks accepted responses.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_t got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request('{req_tuser, req_tdata});
            accepted_reqs++;
            req_accepted = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[1:0], rsp_tdata[20:0], rsp_tdata[29:21],
                    rsp_tlast, rsp_tuser[2], rsp_tuser[3]};
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected response kind=%0d cp=%h", got.kind, got.cp);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: response mismatch exp kind=%0d cp=%h cnt=%0d last=%b ",
                               "none=%b ovf=%b / got kind=%0d cp=%h cnt=%0d last=%b ",
                               "none=%b ovf=%b"},
                              want.kind, want.cp, want.count, want.last, want.empty,
                              want.ovf, got.kind, got.cp, got.count, got.last,
                              got.empty, got.ovf);
               end
            end
         end
         // watchdog: cycles with no transaction on either channel
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else if (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) timed_out = 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_req(input logic [1:0] oper, input logic [7:0] data);
      pending_reqs.insert(pending_reqs.size(), '{oper, data});
   endtask

   // random UTF-8-ish byte: ascii, leads, continuations, invalid, from a small alphabet
   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(9, 0);
      case (sel)
         0, 1, 2: return 8'h61 + 8'($urandom_range(3, 0));
         3: return 8'hC3;
         4: return 8'hE2;
         5: return 8'hF0;
         6: return 8'h80 | 8'($urandom_range(3, 0));
         7: return 8'($urandom_range(255, 0));
         default: return 8'hA9;
      endcase
   endfunction

   // one diff session: random strings, compute, read all ops plus extra
   task automatic queue_session(input int max_len);
      int na, nb, ko, kn, k, nrd;
      na = $urandom_range(max_len, 0);
      nb = $urandom_range(max_len, 0);
      ko = 0;
      kn = 0;
      // interleave appends to both stores
      while (ko < na || kn < nb) begin
         if (kn >= nb || (ko < na && $urandom_range(1, 0))) begin
            queue_req(OPER_APPEND_OLD, pick_byte());
            ko++;
         end else begin
            queue_req(OPER_APPEND_NEW, pick_byte());
            kn++;
         end
      end
      queue_req(OPER_COMPUTE, 8'($urandom_range(255, 0)));
      nrd = na + nb + $urandom_range(2, 0);
      for (k = 0; k < nrd; k++)
         queue_req(OPER_READ, 8'($urandom_range(255, 0)));
   endtask

   task automatic wait_drained();
      while ((pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
             && !timed_out)
         @(posedge clock);
      // a trailing append may still be in flight
      repeat (20) @(posedge clock);
   endtask

   task automatic write_cleanup(input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      merge_en = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int p, s, k;
      old_len = 0;
      new_len = 0;
      script_len = 0;
      script_ptr = 0;
      bytes_lost = 1'b0;
      merge_en = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: read before any compute, empty compute, extremes
      queue_req(OPER_READ, 8'hFF);
      queue_req(OPER_COMPUTE, 8'h00);
      queue_req(OPER_READ, 8'h00);
      // two- and four-byte code points against a three-byte one, invalid,
      // stray continuation and a truncated lead
      queue_req(OPER_APPEND_OLD, 8'h00);
      queue_req(OPER_APPEND_OLD, 8'hC3);
      queue_req(OPER_APPEND_OLD, 8'hA9);
      queue_req(OPER_APPEND_OLD, 8'hF4);
      queue_req(OPER_APPEND_OLD, 8'h8F);
      queue_req(OPER_APPEND_OLD, 8'hBF);
      queue_req(OPER_APPEND_OLD, 8'hBF);
      queue_req(OPER_APPEND_NEW, 8'hE2);
      queue_req(OPER_APPEND_NEW, 8'h82);
      queue_req(OPER_APPEND_NEW, 8'hAC);
      queue_req(OPER_APPEND_NEW, 8'hFF);
      queue_req(OPER_APPEND_NEW, 8'h80);
      queue_req(OPER_APPEND_NEW, 8'h7F);
      queue_req(OPER_APPEND_NEW, 8'hE2);
      queue_req(OPER_COMPUTE, 8'hFF);
      for (k = 0; k < 9; k++) queue_req(OPER_READ, 8'h55);
      wait_drained();

      // tie case with cleanup on: "ab" vs "ba" gives a delete, a keep and an insert
      write_cleanup(1'b1);
      queue_req(OPER_APPEND_OLD, 8'h61);
      queue_req(OPER_APPEND_OLD, 8'h62);
      queue_req(OPER_APPEND_NEW, 8'h62);
      queue_req(OPER_APPEND_NEW, 8'h61);
      queue_req(OPER_COMPUTE, 8'h00);
      for (k = 0; k < 4; k++) queue_req(OPER_READ, 8'h00);
      wait_drained();

      // capacity: overfill old store, then a full-size compute
      for (k = 0; k < STORE_DEPTH + 2; k++) queue_req(OPER_APPEND_OLD, pick_byte());
      for (k = 0; k < 6; k++) queue_req(OPER_APPEND_NEW, pick_byte());
      queue_req(OPER_COMPUTE, 8'h00);
      for (k = 0; k < 8; k++) queue_req(OPER_READ, 8'h00);
      wait_drained();

      // pressure: receiver holds off while requests keep coming
      hold_off_cycles = 300;
      for (k = 0; k < 30; k++) queue_req(OPER_READ, 8'h00);
      queue_session(6);
      wait_drained();

      // random phases: none, sender idle, receiver stall, both
      for (p = 0; p < 8; p++) begin
         write_cleanup(p[0]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         for (s = 0; s < 6; s++) begin
            if (($urandom_range(9, 0)) == 0) begin
               // noise: stray reads and computes
               queue_req(OPER_READ, 8'($urandom_range(255, 0)));
               queue_req(OPER_COMPUTE, 8'($urandom_range(255, 0)));
            end else begin
               queue_session(8);
            end
         end
         wait_drained();
      end

      write_cleanup(1'b0);
      wait_drained();
      if (!timed_out) begin
         if (mismatches == 0 && expected_rsps.size() == 0)
            $display("utf8_lcs_char_diff_unit test passed");
         else
            $display("utf8_lcs_char_diff_unit test failed");
         $finish;
      end
   end

   // timeout path
   always @(posedge clock) begin
      if (timed_out) begin
         $display("utf8_lcs_char_diff_unit test failed");
         $finish;
      end
   end

endmodule
